// ===== rtl/ddo_pkg.sv =====
package ddo_pkg;

    // Number format of the pose and of all intermediate values.
    localparam int WORD_W = 32;
    localparam int FRAC   = 16;

    // Unit widths: magnitude product, shifted dividend and rounded quotient.
    localparam int PROD_W = 2 * WORD_W;
    localparam int NUM_W  = WORD_W + FRAC;
    localparam int QUO_W  = NUM_W + 1;

    // Angle constants, Q30 for the CORDIC and rounded to nearest to the word format.
    localparam int    CQ          = 30;
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint Q30_HALF   = 64'sd1 <<< (CQ - 1 - FRAC);

    localparam logic signed [WORD_W-1:0] PI_Q =
        WORD_W'((PI_Q30 + Q30_HALF) >>> (CQ - FRAC));
    localparam logic signed [WORD_W-1:0] TWO_PI_Q =
        WORD_W'((TWO_PI_Q30 + Q30_HALF) >>> (CQ - FRAC));
    localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(64'sd1 <<< FRAC);

    // Gyro mode codes.
    localparam logic [1:0] MODE_WHEEL = 2'd0;
    localparam logic [1:0] MODE_GYRO  = 2'd1;
    localparam logic [1:0] MODE_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_TRACK = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [WORD_W-1:0] left_dist;
        logic signed [WORD_W-1:0] right_dist;
        logic signed [WORD_W-1:0] gyro_angle;
        logic signed [WORD_W-1:0] set_x;
        logic signed [WORD_W-1:0] set_y;
        logic signed [WORD_W-1:0] set_heading;
    } t_odo_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] heading;
        logic                     moved;
    } t_odo_out;

    // Magnitude of a signed word; the most negative value maps to 2^(W-1).
    function automatic logic [WORD_W-1:0] ddo_mag(input logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Saturate a sum that grew by one bit back to the word range.
    function automatic logic signed [WORD_W-1:0] ddo_sat(input logic signed [WORD_W:0] v);
        logic signed [WORD_W-1:0] res;
        if (v[WORD_W] != v[WORD_W-1]) begin
            res = v[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

    // Sign and magnitude to a saturated signed word.
    function automatic logic signed [WORD_W-1:0] ddo_from_sm(input logic neg,
                                                             input logic [QUO_W-1:0] m);
        logic [QUO_W-1:0]         lim;
        logic signed [WORD_W-1:0] res;
        lim = QUO_W'({1'b0, {(WORD_W-1){1'b1}}}) + QUO_W'(neg);
        if (m > lim) begin
            res = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else if (neg) begin
            res = -m[WORD_W-1:0];
        end else begin
            res = m[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ddo_mul.sv =====
module ddo_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ddo_pkg::WORD_W-1:0] i_a,
    input  logic signed [ddo_pkg::WORD_W-1:0] i_b,
    output logic                          o_done,
    output logic signed [ddo_pkg::WORD_W-1:0] o_res
);
    import ddo_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic              r_stage;
    logic              r_done;
    logic signed [WORD_W-1:0] r_res;
    logic [PROD_W:0]   rnd_sum;

    // Round to nearest, ties away from zero, on the magnitude.
    assign rnd_sum = {1'b0, r_prod} + ((PROD_W + 1)'(1) << (FRAC - 1));

    // Stage one multiplies magnitudes, stage two rounds and saturates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
        if (i_start) begin
            r_prod <= PROD_W'(ddo_mag(i_a)) * PROD_W'(ddo_mag(i_b));
            r_neg  <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
        end
        if (r_stage) begin
            r_res <= ddo_from_sm(r_neg, rnd_sum[PROD_W:FRAC]);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/ddo_div.sv =====
module ddo_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddo_pkg::NUM_W-1:0]     i_num,
    input  logic [ddo_pkg::WORD_W-1:0]    i_den,
    input  logic                          i_neg,
    output logic                          o_done,
    output logic signed [ddo_pkg::WORD_W-1:0] o_quo,
    output logic [ddo_pkg::WORD_W-1:0]    o_rem
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quo;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_den;
    logic              r_neg;
    logic              r_zero;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_fin;
    logic              r_done;
    logic signed [WORD_W-1:0] r_res;

    logic [WORD_W:0]   trial;
    logic              fits;
    logic              rnd_up;
    logic [QUO_W-1:0]  quo_rnd;

    // One restoring step per cycle.
    assign trial   = {r_rem, r_num[NUM_W-1]};
    assign fits    = trial >= {1'b0, r_den};
    assign rnd_up  = r_rem >= (r_den - r_rem);
    assign quo_rnd = {1'b0, r_quo} + QUO_W'(rnd_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == CNT_W'(NUM_W - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_neg  <= i_neg;
            r_zero <= (i_num == '0);
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_num <= r_num << 1;
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? WORD_W'(trial - {1'b0, r_den}) : trial[WORD_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
        // Final rounding; a zero dividend gives zero, a zero divisor saturates by the quotient's sign.
        if (r_fin) begin
            if (r_zero) begin
                r_res <= '0;
            end else if (r_den == '0) begin
                r_res <= ddo_from_sm(r_neg, {QUO_W{1'b1}});
            end else begin
                r_res <= ddo_from_sm(r_neg, quo_rnd);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_res;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/ddo_cordic.sv =====
module ddo_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ddo_pkg::WORD_W-1:0] i_ang,
    output logic                          o_done,
    output logic signed [ddo_pkg::WORD_W-1:0] o_sin,
    output logic signed [ddo_pkg::WORD_W-1:0] o_cos
);
    import ddo_pkg::*;

    localparam int Z_W   = 34;
    localparam int STEPS = 30;
    localparam int CNT_W = 5;

    localparam logic signed [Z_W-1:0] GAIN    = 34'sd652032874;
    localparam logic signed [Z_W-1:0] PI_Z    = Z_W'(PI_Q30);
    localparam logic signed [Z_W-1:0] HALF_PI = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] RND     = Z_W'(Q30_HALF);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FLIP = 2'd2;
    localparam logic [1:0] PH_OUT  = 2'd3;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic [1:0]            r_phase;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [Z_W-1:0] r_x;
    logic signed [Z_W-1:0] r_y;
    logic signed [Z_W-1:0] r_z;
    logic                  r_flip;
    logic                  r_done;
    logic signed [WORD_W-1:0] r_sin;
    logic signed [WORD_W-1:0] r_cos;

    logic signed [Z_W-1:0] z0;
    logic signed [Z_W-1:0] sx;
    logic signed [Z_W-1:0] sy;
    logic signed [Z_W-1:0] x_rnd;
    logic signed [Z_W-1:0] y_rnd;

    // Angle in Q30; it is already reduced to within pi.
    assign z0    = Z_W'(signed'({{(Z_W-WORD_W){i_ang[WORD_W-1]}}, i_ang}) <<< (CQ - FRAC));
    assign sx    = r_x >>> r_cnt;
    assign sy    = r_y >>> r_cnt;
    assign x_rnd = (r_x + RND) >>> (CQ - FRAC);
    assign y_rnd = (r_y + RND) >>> (CQ - FRAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_RUN;
                    end
                end
                PH_RUN: begin
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_phase <= PH_FLIP;
                    end
                end
                PH_FLIP: begin
                    r_phase <= PH_OUT;
                end
                PH_OUT: begin
                    r_phase <= PH_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
        // Fold the angle into the right half plane, then rotate.
        if (i_start && r_phase == PH_IDLE) begin
            r_x   <= GAIN;
            r_y   <= '0;
            r_cnt <= '0;
            if (z0 > HALF_PI) begin
                r_z    <= z0 - PI_Z;
                r_flip <= 1'b1;
            end else if (z0 < -HALF_PI) begin
                r_z    <= z0 + PI_Z;
                r_flip <= 1'b1;
            end else begin
                r_z    <= z0;
                r_flip <= 1'b0;
            end
        end else if (r_phase == PH_RUN) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_z >= 0) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - atan_q30(r_cnt);
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + atan_q30(r_cnt);
            end
        end else if (r_phase == PH_FLIP && r_flip) begin
            r_x <= -r_x;
            r_y <= -r_y;
        end else if (r_phase == PH_OUT) begin
            r_sin <= y_rnd[WORD_W-1:0];
            r_cos <= x_rnd[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

// ===== rtl/diff_drive_odometry_update.sv =====
// Differential-drive arc odometry with a fixed-point pose register.
//
// Input channel (i_in_valid / o_in_ready, payload t_odo_in): one transfer is
// either a set-pose command or one odometry sample. Output channel
// (o_out_valid / i_out_ready, payload t_odo_out): exactly one result per
// input transfer, holding the pose after that item and the moved flag.
// Configuration goes through the APB port: track width at 0x0, gyro mode at
// 0x4; pready is always high and reads return the register value.
//
// Each item is worked by a sequencer that drives one saturating adder, a
// two-stage multiplier, a 48-step restoring divider and a 30-step CORDIC.
// A set-pose item or a sample with zero track width goes straight to the
// finish step. Most of the time of a straight or an arc step, also with
// full gyro correction, goes to the divider. o_in_ready is high only while
// the sequencer is idle. The result sits in an output register, so a stalled
// receiver does not stop the next item from being worked; it only holds the
// finish step until the register is free.
// Reset clears the pose, the configuration and both channels.
module diff_drive_odometry_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ddo_pkg::t_odo_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ddo_pkg::t_odo_out   o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ddo_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CHK  = 5'd1;
    localparam logic [4:0] ST_C1   = 5'd2;
    localparam logic [4:0] ST_C2   = 5'd3;
    localparam logic [4:0] ST_C3   = 5'd4;
    localparam logic [4:0] ST_C4   = 5'd5;
    localparam logic [4:0] ST_C5   = 5'd6;
    localparam logic [4:0] ST_C7   = 5'd7;
    localparam logic [4:0] ST_C8   = 5'd8;
    localparam logic [4:0] ST_C9   = 5'd9;
    localparam logic [4:0] ST_C10  = 5'd10;
    localparam logic [4:0] ST_RD   = 5'd11;
    localparam logic [4:0] ST_RA   = 5'd12;
    localparam logic [4:0] ST_RC   = 5'd13;
    localparam logic [4:0] ST_A1   = 5'd14;
    localparam logic [4:0] ST_A2   = 5'd15;
    localparam logic [4:0] ST_A3   = 5'd16;
    localparam logic [4:0] ST_A4   = 5'd17;
    localparam logic [4:0] ST_A5   = 5'd18;
    localparam logic [4:0] ST_A6   = 5'd19;
    localparam logic [4:0] ST_A7   = 5'd20;
    localparam logic [4:0] ST_A8   = 5'd21;
    localparam logic [4:0] ST_A9   = 5'd22;
    localparam logic [4:0] ST_A10  = 5'd23;
    localparam logic [4:0] ST_A11  = 5'd24;
    localparam logic [4:0] ST_A12  = 5'd25;
    localparam logic [4:0] ST_S1   = 5'd26;
    localparam logic [4:0] ST_S2   = 5'd27;
    localparam logic [4:0] ST_S3   = 5'd28;
    localparam logic [4:0] ST_S4   = 5'd29;
    localparam logic [4:0] ST_FIN  = 5'd30;

    // Configuration registers.
    logic [30:0] r_track;
    logic [1:0]  r_mode;

    // Pose and working registers.
    logic signed [WORD_W-1:0] r_x, r_y, r_head;
    logic signed [WORD_W-1:0] r_l, r_r, r_g, r_w;
    logic signed [WORD_W-1:0] r_t, r_u, r_v;
    logic signed [WORD_W-1:0] r_ang, r_red;
    logic signed [WORD_W-1:0] r_s0, r_c0, r_s1, r_c1;
    logic        r_pass;
    logic        r_moved;
    logic [4:0]  r_state;
    logic        r_wait;
    logic        r_out_valid;
    t_odo_out    r_out;

    // Shared datapath operands.
    logic signed [WORD_W-1:0] alu_a, alu_b, alu_res;
    logic                     alu_sub;
    logic signed [WORD_W:0]   alu_sum;
    logic signed [WORD_W-1:0] mul_a, mul_b, mul_res;
    logic [NUM_W-1:0]         div_num;
    logic [WORD_W-1:0]        div_den, div_rem;
    logic                     div_neg;
    logic signed [WORD_W-1:0] div_res;
    logic signed [WORD_W-1:0] red_ang;
    logic signed [WORD_W-1:0] cor_sin, cor_cos;
    logic is_mul, is_div, is_cor, unit_done;
    logic mul_done, div_done, cor_done;
    logic in_xfer, cfg_wr;

    assign in_xfer = i_in_valid && o_in_ready;
    assign cfg_wr  = psel && penable && pwrite;
    assign red_ang = r_pass ? r_ang : r_head;

    // Which unit the current step waits on.
    always_comb begin
        is_mul = (r_state == ST_C2) || (r_state == ST_C8) || (r_state == ST_C10) ||
                 (r_state == ST_A3) || (r_state == ST_A8) || (r_state == ST_A11) ||
                 (r_state == ST_S1) || (r_state == ST_S3);
        is_div = (r_state == ST_C5) || (r_state == ST_A2) || (r_state == ST_A4) ||
                 (r_state == ST_RD);
        is_cor = (r_state == ST_RC);
    end
    assign unit_done = mul_done || div_done || cor_done;

    // Saturating adder operands for each step.
    always_comb begin
        alu_a   = r_x;
        alu_b   = r_u;
        alu_sub = 1'b0;
        unique case (r_state)
            ST_CHK: begin alu_a = r_r;   alu_b = r_l; end
            ST_C1:  begin alu_a = r_g;   alu_b = r_head; alu_sub = 1'b1; end
            ST_C3:  begin alu_a = r_r;   alu_b = r_l;    alu_sub = 1'b1; end
            ST_C4:  begin alu_a = r_u;   alu_b = r_t;    alu_sub = 1'b1; end
            ST_C7:  begin alu_a = ONE_Q; alu_b = r_t; end
            ST_C9:  begin alu_a = ONE_Q; alu_b = r_t;    alu_sub = 1'b1; end
            ST_A1:  begin alu_a = r_r;   alu_b = r_l;    alu_sub = 1'b1; end
            ST_A5:  begin alu_a = r_t;   alu_b = r_w >>> 1; end
            ST_A6:  begin alu_a = r_head; alu_b = r_v; end
            ST_A7:  begin alu_a = r_s1;  alu_b = r_s0;   alu_sub = 1'b1; end
            ST_A10: begin alu_a = r_c0;  alu_b = r_c1;   alu_sub = 1'b1; end
            ST_A12, ST_S4: begin alu_a = r_y; alu_b = r_u; end
            default: begin alu_a = r_x;  alu_b = r_u; end
        endcase
        alu_sum = alu_sub ? ({alu_a[WORD_W-1], alu_a} - {alu_b[WORD_W-1], alu_b})
                          : ({alu_a[WORD_W-1], alu_a} + {alu_b[WORD_W-1], alu_b});
        alu_res = ddo_sat(alu_sum);
    end

    // Multiplier operands.
    always_comb begin
        unique case (r_state)
            ST_C2:  begin mul_a = r_w; mul_b = r_t;  end
            ST_C8:  begin mul_a = r_l; mul_b = r_u;  end
            ST_C10: begin mul_a = r_r; mul_b = r_u;  end
            ST_A3:  begin mul_a = r_l; mul_b = r_w;  end
            ST_S1:  begin mul_a = r_l; mul_b = r_c0; end
            ST_S3:  begin mul_a = r_l; mul_b = r_s0; end
            default: begin mul_a = r_t; mul_b = r_u; end
        endcase
    end

    // Divider operands; angle reduction uses the remainder.
    always_comb begin
        unique case (r_state)
            ST_C5: begin
                div_num = {ddo_mag(r_t), {FRAC{1'b0}}};
                div_den = ddo_mag(r_v);
                div_neg = r_t[WORD_W-1] ^ r_v[WORD_W-1];
            end
            ST_A2: begin
                div_num = {ddo_mag(r_u), {FRAC{1'b0}}};
                div_den = ddo_mag(r_w);
                div_neg = r_u[WORD_W-1] ^ r_w[WORD_W-1];
            end
            ST_A4: begin
                div_num = {ddo_mag(r_t), {FRAC{1'b0}}};
                div_den = ddo_mag(r_u);
                div_neg = r_t[WORD_W-1] ^ r_u[WORD_W-1];
            end
            default: begin
                div_num = NUM_W'(ddo_mag(red_ang));
                div_den = TWO_PI_Q;
                div_neg = 1'b0;
            end
        endcase
    end

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (is_mul && !r_wait),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (is_div && !r_wait),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_done  (div_done),
        .o_quo   (div_res),
        .o_rem   (div_rem)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (is_cor && !r_wait),
        .i_ang   (r_red),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
            r_mode  <= MODE_WHEEL;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TRACK: r_track <= pwdata[30:0];
                REG_MODE:  r_mode  <= pwdata[1:0];
                default:   r_track <= r_track;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {30'b0, r_mode} : {1'b0, r_track};
    assign pready = 1'b1;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
        end else begin
            // A unit step raises the wait flag at its start and drops it at done.
            if (is_mul || is_div || is_cor) begin
                r_wait <= r_wait ? !unit_done : 1'b1;
            end else begin
                r_wait <= 1'b0;
            end

            // The finish step fills the output register; a transfer empties it.
            if (r_state == ST_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_l    <= i_in_data.left_dist;
                        r_r    <= i_in_data.right_dist;
                        r_g    <= i_in_data.gyro_angle;
                        r_w    <= {1'b0, r_track};
                        r_pass <= 1'b0;
                        if (i_in_data.func) begin
                            r_x     <= i_in_data.set_x;
                            r_y     <= i_in_data.set_y;
                            r_head  <= i_in_data.set_heading;
                            r_moved <= 1'b0;
                            r_state <= ST_FIN;
                        end else if (r_track == '0) begin
                            r_moved <= 1'b0;
                            r_state <= ST_FIN;
                        end else begin
                            r_moved <= 1'b1;
                            r_state <= ST_CHK;
                        end
                    end
                end
                // Gyro correction of both distances.
                ST_CHK: begin
                    r_v <= alu_res;
                    if (r_mode == MODE_FULL && alu_res != '0) begin
                        r_state <= ST_C1;
                    end else begin
                        r_state <= ST_RD;
                    end
                end
                ST_C1: begin r_t <= alu_res; r_state <= ST_C2; end
                ST_C2: begin
                    if (r_wait && mul_done) begin r_t <= mul_res; r_state <= ST_C3; end
                end
                ST_C3: begin r_u <= alu_res; r_state <= ST_C4; end
                ST_C4: begin r_t <= alu_res; r_state <= ST_C5; end
                ST_C5: begin
                    if (r_wait && div_done) begin r_t <= div_res; r_state <= ST_C7; end
                end
                ST_C7: begin r_u <= alu_res; r_state <= ST_C8; end
                ST_C8: begin
                    if (r_wait && mul_done) begin r_l <= mul_res; r_state <= ST_C9; end
                end
                ST_C9: begin r_u <= alu_res; r_state <= ST_C10; end
                ST_C10: begin
                    if (r_wait && mul_done) begin r_r <= mul_res; r_state <= ST_RD; end
                end
                // Angle reduction to within pi, then sine and cosine.
                ST_RD: begin
                    if (r_wait && div_done) begin
                        r_red   <= red_ang[WORD_W-1] ? -div_rem : div_rem;
                        r_state <= ST_RA;
                    end
                end
                ST_RA: begin
                    if (r_red > PI_Q) begin
                        r_red <= r_red - TWO_PI_Q;
                    end else if (r_red < -PI_Q) begin
                        r_red <= r_red + TWO_PI_Q;
                    end
                    r_state <= ST_RC;
                end
                ST_RC: begin
                    if (r_wait && cor_done) begin
                        if (r_pass) begin
                            r_s1    <= cor_sin;
                            r_c1    <= cor_cos;
                            r_state <= ST_A7;
                        end else begin
                            r_s0 <= cor_sin;
                            r_c0 <= cor_cos;
                            if (r_r != r_l && r_l != '0) begin
                                r_state <= ST_A1;
                            end else begin
                                r_state <= ST_S1;
                            end
                        end
                    end
                end
                // Arc step.
                ST_A1: begin r_u <= alu_res; r_state <= ST_A2; end
                ST_A2: begin
                    if (r_wait && div_done) begin r_v <= div_res; r_state <= ST_A3; end
                end
                ST_A3: begin
                    if (r_wait && mul_done) begin r_t <= mul_res; r_state <= ST_A4; end
                end
                ST_A4: begin
                    if (r_wait && div_done) begin r_t <= div_res; r_state <= ST_A5; end
                end
                ST_A5: begin r_t <= alu_res; r_state <= ST_A6; end
                ST_A6: begin
                    r_ang   <= alu_res;
                    r_pass  <= 1'b1;
                    r_state <= ST_RD;
                end
                ST_A7: begin r_u <= alu_res; r_state <= ST_A8; end
                ST_A8: begin
                    if (r_wait && mul_done) begin r_u <= mul_res; r_state <= ST_A9; end
                end
                ST_A9:  begin r_x <= alu_res; r_state <= ST_A10; end
                ST_A10: begin r_u <= alu_res; r_state <= ST_A11; end
                ST_A11: begin
                    if (r_wait && mul_done) begin r_u <= mul_res; r_state <= ST_A12; end
                end
                ST_A12: begin
                    r_y     <= alu_res;
                    r_head  <= (r_mode == MODE_WHEEL) ? r_ang : r_g;
                    r_state <= ST_FIN;
                end
                // Straight step along the current heading.
                ST_S1: begin
                    if (r_wait && mul_done) begin r_u <= mul_res; r_state <= ST_S2; end
                end
                ST_S2: begin r_x <= alu_res; r_state <= ST_S3; end
                ST_S3: begin
                    if (r_wait && mul_done) begin r_u <= mul_res; r_state <= ST_S4; end
                end
                ST_S4: begin r_y <= alu_res; r_state <= ST_FIN; end
                // Hand the pose to the output register once it is free.
                ST_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && (!r_out_valid || i_out_ready)) begin
            r_out.pos_x   <= r_x;
            r_out.pos_y   <= r_y;
            r_out.heading <= r_head;
            r_out.moved   <= r_moved;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
